// ===== hdl/tsop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsop_pkg
// shared types and telnet codes for the telnet server option parser
// ----------------------------------------------------------------------------
package tsop_pkg;

  // telnet command bytes
  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;

  // option codes
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;
  localparam logic [7:0] OPT_NAWS = 8'd31;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_SIZE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [15:0] SIZE_LIMIT_RST = 16'd10000;
  localparam logic [15:0] WIDTH_RST      = 16'd80;
  localparam logic [15:0] HEIGHT_RST     = 16'd24;
  localparam logic [2:0]  SUB_MAX        = 3'd4;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  reply_command;
    logic [7:0]  reply_option;
    logic [15:0] width;
    logic [15:0] height;
    logic        negotiation_done;
    logic        last;
  } out_t;

  // results of one transaction, slot 0 first
  typedef struct packed {
    logic [1:0]              cnt;
    out_t [MAX_RES-1:0]      slot;
  } res_set_t;

  function automatic out_t mk_res(input logic [1:0] kind, input logic [7:0] db,
                                  input logic [7:0] cmd, input logic [7:0] opt,
                                  input logic done);
    out_t r;
    r                  = '0;
    r.kind             = kind;
    r.data_byte        = db;
    r.reply_command    = cmd;
    r.reply_option     = opt;
    r.negotiation_done = done;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tsop_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsop_parser
// telnet byte parser state, negotiation policy and window size tracking
// ----------------------------------------------------------------------------
module tsop_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              accept_i,
  input  wire tsop_pkg::in_t     in_data_i,
  output tsop_pkg::res_set_t     set_o
);
  import tsop_pkg::*;

  typedef enum logic [3:0] {
    PS_NORMAL = 4'd0,
    PS_IAC    = 4'd1,
    PS_WILL   = 4'd2,
    PS_WONT   = 4'd3,
    PS_DO     = 4'd4,
    PS_DONT   = 4'd5,
    PS_SB     = 4'd6,
    PS_INSB   = 4'd7,
    PS_SBIAC  = 4'd8
  } ps_e;

  ps_e         state_q, state_d;
  logic [15:0] limit_q;
  logic [7:0]  sub_opt_q, sub_opt_d;
  logic [2:0]  sub_cnt_q, sub_cnt_d;
  logic [31:0] sub_bytes_q, sub_bytes_d;
  logic        echo_q, echo_d;
  logic        sga_q, sga_d;
  logic        done_q, done_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;

  logic [7:0]  c;
  logic [7:0]  cmd;
  logic [2:0]  push_cnt;
  logic [31:0] push_bytes;
  logic [15:0] fin_w, fin_h;
  logic        fin_ok;
  logic [1:0]  n;
  res_set_t    set;

  assign c = in_data_i.rx_byte;

  // command byte held by the current state
  always_comb begin
    unique case (state_q)
      PS_WILL: cmd = T_WILL;
      PS_WONT: cmd = T_WONT;
      PS_DO:   cmd = T_DO;
      default: cmd = T_DONT;
    endcase
  end

  // subnegotiation byte capture, first byte in the top lane
  always_comb begin
    push_cnt   = sub_cnt_q;
    push_bytes = sub_bytes_q;
    if (sub_cnt_q < SUB_MAX) begin
      push_cnt = sub_cnt_q + 3'd1;
      case (sub_cnt_q[1:0])
        2'd0:    push_bytes[31:24] = c;
        2'd1:    push_bytes[23:16] = c;
        2'd2:    push_bytes[15:8]  = c;
        default: push_bytes[7:0]   = c;
      endcase
    end
  end

  assign fin_w  = sub_bytes_q[31:16];
  assign fin_h  = sub_bytes_q[15:0];
  assign fin_ok = (sub_opt_q == OPT_NAWS) && (sub_cnt_q >= SUB_MAX) &&
                  (fin_w != 16'd0) && (fin_w < limit_q) &&
                  (fin_h != 16'd0) && (fin_h < limit_q);

  always_comb begin
    state_d     = state_q;
    sub_opt_d   = sub_opt_q;
    sub_cnt_d   = sub_cnt_q;
    sub_bytes_d = sub_bytes_q;
    echo_d      = echo_q;
    sga_d       = sga_q;
    done_d      = done_q;
    width_d     = width_q;
    height_d    = height_q;
    n           = 2'd0;
    set         = '0;
    if (accept_i) begin
      if (in_data_i.action) begin
        set.slot[0] = mk_res(KIND_CMD, 8'd0, T_WILL, OPT_ECHO, done_q);
        set.slot[1] = mk_res(KIND_CMD, 8'd0, T_WILL, OPT_SGA, done_q);
        set.slot[2] = mk_res(KIND_CMD, 8'd0, T_DO, OPT_NAWS, done_q);
        n           = 2'd3;
      end else begin
        unique case (state_q)
          PS_IAC: begin
            state_d = PS_NORMAL;
            case (c)
              T_IAC: begin
                set.slot[0] = mk_res(KIND_DATA, c, 8'd0, 8'd0, done_q);
                n           = 2'd1;
              end
              T_WILL:  state_d = PS_WILL;
              T_WONT:  state_d = PS_WONT;
              T_DO:    state_d = PS_DO;
              T_DONT:  state_d = PS_DONT;
              T_SB:    state_d = PS_SB;
              default: state_d = PS_NORMAL;
            endcase
          end
          PS_WILL, PS_WONT, PS_DO, PS_DONT: begin
            state_d = PS_NORMAL;
            if ((cmd == T_DO) || (cmd == T_DONT)) begin
              if (c == OPT_ECHO) begin
                echo_d = 1'b1;
              end else if (c == OPT_SGA) begin
                sga_d = 1'b1;
              end else if (cmd == T_DO) begin
                set.slot[0] = mk_res(KIND_CMD, 8'd0, T_WONT, c, done_q);
                n           = 2'd1;
              end
            end else if ((c != OPT_NAWS) && (cmd == T_WILL)) begin
              set.slot[0] = mk_res(KIND_CMD, 8'd0, T_DONT, c, done_q);
              n           = 2'd1;
            end
            if (!done_q && echo_d && sga_d) begin
              done_d      = 1'b1;
              set.slot[n] = mk_res(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b1);
              n           = n + 2'd1;
            end
          end
          PS_SB: begin
            sub_opt_d   = c;
            sub_cnt_d   = 3'd0;
            sub_bytes_d = 32'd0;
            state_d     = PS_INSB;
          end
          PS_INSB: begin
            if (c == T_IAC) begin
              state_d = PS_SBIAC;
            end else begin
              sub_cnt_d   = push_cnt;
              sub_bytes_d = push_bytes;
            end
          end
          PS_SBIAC: begin
            if (c == T_IAC) begin
              sub_cnt_d   = push_cnt;
              sub_bytes_d = push_bytes;
              state_d     = PS_INSB;
            end else begin
              state_d = PS_NORMAL;
              if (fin_ok) begin
                width_d     = fin_w;
                height_d    = fin_h;
                set.slot[0] = mk_res(KIND_SIZE, 8'd0, 8'd0, 8'd0, done_q);
                n           = 2'd1;
              end
            end
          end
          default: begin
            if (c == T_IAC) begin
              state_d = PS_IAC;
            end else begin
              state_d     = PS_NORMAL;
              set.slot[0] = mk_res(KIND_DATA, c, 8'd0, 8'd0, done_q);
              n           = 2'd1;
            end
          end
        endcase
      end
    end
    for (int i = 0; i < MAX_RES; i++) begin
      set.slot[i].width  = width_d;
      set.slot[i].height = height_d;
    end
    set.cnt = n;
  end

  assign set_o = set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PS_NORMAL;
      limit_q     <= SIZE_LIMIT_RST;
      sub_opt_q   <= 8'd0;
      sub_cnt_q   <= 3'd0;
      sub_bytes_q <= 32'd0;
      echo_q      <= 1'b0;
      sga_q       <= 1'b0;
      done_q      <= 1'b0;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else begin
      state_q     <= state_d;
      sub_opt_q   <= sub_opt_d;
      sub_cnt_q   <= sub_cnt_d;
      sub_bytes_q <= sub_bytes_d;
      echo_q      <= echo_d;
      sga_q       <= sga_d;
      done_q      <= done_d;
      width_q     <= width_d;
      height_q    <= height_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tsop_res_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsop_res_buf
// result register holding the results of one transaction, drained in order
// ----------------------------------------------------------------------------
module tsop_res_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire tsop_pkg::res_set_t set_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tsop_pkg::out_t          out_data_o
);
  import tsop_pkg::*;

  out_t [MAX_RES-1:0] slot_q;
  logic [1:0]         rem_q;
  logic               take;

  assign out_valid_o = (rem_q != 2'd0);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (take && (rem_q == 2'd1));

  always_comb begin
    out_data_o      = slot_q[0];
    out_data_o.last = (rem_q == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (load_i && (set_i.cnt != 2'd0)) begin
      rem_q <= set_i.cnt;
    end else if (take) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  // payload shifts toward slot 0 as results leave
  always_ff @(posedge clk_i) begin
    if (load_i && (set_i.cnt != 2'd0)) begin
      slot_q <= set_i.slot;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/telnet_server_option_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_server_option_parser
// telnet receive parser with option negotiation policy and window size
// ----------------------------------------------------------------------------
// One input transaction is taken per cycle while the result register is empty
// or is handing out the final result of the previous transaction. Each
// transaction yields zero to three results, and the result register hands out
// one result per cycle while the receiver does not stall, so a byte, which has
// at most one result, sustains one transaction per cycle; a start action (three
// results) holds the input until its final result is being handed out.
// A byte that causes no result loads nothing, but it still waits while earlier
// results are pending or the receiver stalls.
// size_limit is to be written through cfg_we_i and cfg_wdata_i only while idle; the block does not enforce this.
module telnet_server_option_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire tsop_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output tsop_pkg::out_t       out_data_o
);
  import tsop_pkg::*;

  res_set_t set;
  logic     free;
  logic     accept;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  tsop_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .set_o       (set)
  );

  tsop_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .set_i       (set),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telnet server option parser. A transaction-level
// model of the parser tracks the telnet parse state, option settlement and
// window size, and predicts every result of each accepted byte or start
// transaction. Results are compared field by field in order. Bytes come as
// directed sequences and then as random telnet traffic of data bytes, commands,
// NAWS and other subnegotiations and start actions, with some noise. The size
// limit changes between phases, and sender gaps and receiver stalls vary from
// phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import tsop_pkg::*;

  typedef enum logic [3:0] {
    PS_NORMAL, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SB, PS_INSB, PS_SBIAC
  } parse_state_e;

  class telnet_scoreboard;
    logic [15:0]  size_limit;
    parse_state_e state;
    logic [7:0]   sub_option;
    logic [2:0]   sub_count;
    logic [31:0]  sub_bytes;
    bit           echo_settled;
    bit           sga_settled;
    bit           naws_settled;
    bit           done_flag;
    logic [15:0]  cur_width;
    logic [15:0]  cur_height;
    out_t         expected_q[$];
    int           errors;

    function new();
      size_limit   = SIZE_LIMIT_RST;
      state        = PS_NORMAL;
      sub_option   = '0;
      sub_count    = '0;
      sub_bytes    = '0;
      echo_settled = 1'b0;
      sga_settled  = 1'b0;
      naws_settled = 1'b0;
      done_flag    = 1'b0;
      cur_width    = WIDTH_RST;
      cur_height   = HEIGHT_RST;
      errors       = 0;
    endfunction

    function void set_size_limit(logic [15:0] value);
      size_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] db, logic [7:0] cmd,
                             logic [7:0] opt);
      out_t r;
      r.kind             = kind;
      r.data_byte        = db;
      r.reply_command    = cmd;
      r.reply_option     = opt;
      r.width            = cur_width;
      r.height           = cur_height;
      r.negotiation_done = done_flag;
      r.last             = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void push_sub_byte(logic [7:0] b);
      if (sub_count < SUB_MAX) begin
        sub_bytes = sub_bytes | ({24'd0, b} << (8 * (3 - sub_count)));
        sub_count = sub_count + 3'd1;
      end
    endfunction

    function void finish_sub();
      logic [15:0] w;
      logic [15:0] h;
      w = sub_bytes[31:16];
      h = sub_bytes[15:0];
      if (sub_option == OPT_NAWS && sub_count >= SUB_MAX && w != 16'd0 &&
          w < size_limit && h != 16'd0 && h < size_limit) begin
        cur_width  = w;
        cur_height = h;
        add_result(KIND_SIZE, 8'd0, 8'd0, 8'd0);
      end
    endfunction

    function void answer_command(logic [7:0] cmd, logic [7:0] opt);
      if (cmd == T_DO || cmd == T_DONT) begin
        if (opt == OPT_ECHO) echo_settled = 1'b1;
        else if (opt == OPT_SGA) sga_settled = 1'b1;
        else if (cmd == T_DO) add_result(KIND_CMD, 8'd0, T_WONT, opt);
      end else begin
        if (opt == OPT_NAWS) naws_settled = 1'b1;
        else if (cmd == T_WILL) add_result(KIND_CMD, 8'd0, T_DONT, opt);
      end
      if (!done_flag && echo_settled && sga_settled) begin
        done_flag = 1'b1;
        add_result(KIND_DONE, 8'd0, 8'd0, 8'd0);
      end
    endfunction

    function void note_input(in_t trans);
      int         first;
      logic [7:0] c;
      out_t       tail;
      first = expected_q.size();
      c     = trans.rx_byte;
      if (trans.action) begin
        add_result(KIND_CMD, 8'd0, T_WILL, OPT_ECHO);
        add_result(KIND_CMD, 8'd0, T_WILL, OPT_SGA);
        add_result(KIND_CMD, 8'd0, T_DO, OPT_NAWS);
      end else begin
        case (state)
          PS_IAC: begin
            state = PS_NORMAL;
            if (c == T_IAC) add_result(KIND_DATA, c, 8'd0, 8'd0);
            else if (c == T_WILL) state = PS_WILL;
            else if (c == T_WONT) state = PS_WONT;
            else if (c == T_DO) state = PS_DO;
            else if (c == T_DONT) state = PS_DONT;
            else if (c == T_SB) state = PS_SB;
          end
          PS_WILL: begin
            state = PS_NORMAL;
            answer_command(T_WILL, c);
          end
          PS_WONT: begin
            state = PS_NORMAL;
            answer_command(T_WONT, c);
          end
          PS_DO: begin
            state = PS_NORMAL;
            answer_command(T_DO, c);
          end
          PS_DONT: begin
            state = PS_NORMAL;
            answer_command(T_DONT, c);
          end
          PS_SB: begin
            sub_option = c;
            sub_count  = '0;
            sub_bytes  = '0;
            state      = PS_INSB;
          end
          PS_INSB: begin
            if (c == T_IAC) state = PS_SBIAC;
            else push_sub_byte(c);
          end
          PS_SBIAC: begin
            if (c == T_IAC) begin
              push_sub_byte(c);
              state = PS_INSB;
            end else begin
              finish_sub();
              state = PS_NORMAL;
            end
          end
          default: begin
            state = PS_NORMAL;
            if (c == T_IAC) state = PS_IAC;
            else add_result(KIND_DATA, c, 8'd0, 8'd0);
          end
        endcase
      end
      if (expected_q.size() > first) begin
        tail      = expected_q[expected_q.size() - 1];
        tail.last = 1'b1;
        expected_q[expected_q.size() - 1] = tail;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare_field("reply_command", 16'(want.reply_command), 16'(got.reply_command));
      compare_field("reply_option", 16'(want.reply_option), 16'(got.reply_option));
      compare_field("width", want.width, got.width);
      compare_field("height", want.height, got.height);
      compare_field("negotiation_done", 16'(want.negotiation_done),
                    16'(got.negotiation_done));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  in_t         in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_t        out_data_o;

  int               sender_idle_pct    = 0;
  int               receiver_stall_pct = 0;
  int               items_sent         = 0;
  telnet_scoreboard sb;

  telnet_server_option_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic send_item(input in_t trans);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= trans;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(trans);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t trans;
    trans.action  = 1'b0;
    trans.rx_byte = b;
    send_item(trans);
  endtask

  task automatic send_start(input logic [7:0] junk);
    in_t trans;
    trans.action  = 1'b1;
    trans.rx_byte = junk;
    send_item(trans);
  endtask

  // IAC inside a subnegotiation payload goes out doubled
  task automatic send_subneg(input logic [7:0] opt, input logic [31:0] payload,
                             input int len, input logic [7:0] term);
    logic [7:0] b;
    send_byte(T_IAC);
    send_byte(T_SB);
    send_byte(opt);
    for (int i = 0; i < len; i++) begin
      b = (i < 4) ? payload[31 - 8 * i -: 8] : 8'($urandom_range(0, 255));
      send_byte(b);
      if (b == T_IAC) send_byte(T_IAC);
    end
    send_byte(T_IAC);
    send_byte(term);
  endtask

  function automatic logic [15:0] pick_dimension();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return sb.size_limit - 16'd1;
      3: return sb.size_limit;
      4: return 16'($urandom_range(2, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 254));
    return T_SE;
  endfunction

  task automatic send_random_sequence();
    int         r;
    int         len;
    logic [7:0] cmd;
    logic [7:0] opt;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (r < 38) begin
      send_byte(T_IAC);
      send_byte(T_IAC);
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: cmd = T_WILL;
        1: cmd = T_WONT;
        2: cmd = T_DO;
        default: cmd = T_DONT;
      endcase
      case ($urandom_range(0, 4))
        0: opt = OPT_ECHO;
        1: opt = OPT_SGA;
        2: opt = OPT_NAWS;
        default: opt = 8'($urandom_range(0, 255));
      endcase
      send_byte(T_IAC);
      send_byte(cmd);
      send_byte(opt);
    end else if (r < 80) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
      send_subneg(OPT_NAWS, {pick_dimension(), pick_dimension()}, len, pick_terminator());
    end else if (r < 86) begin
      opt = 8'($urandom_range(0, 255));
      if (opt == OPT_NAWS) opt = OPT_ECHO;
      send_subneg(opt, $urandom, $urandom_range(0, 5), pick_terminator());
    end else if (r < 90) begin
      send_start(8'($urandom_range(0, 255)));
    end else if (r < 96) begin
      send_byte(T_IAC);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_size_limit(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_size_limit(value);
  endtask

  initial begin
    int          phase_end;
    logic [15:0] limit;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed traffic at the reset size limit
    send_byte(8'h00);
    send_start(8'hFF);
    send_byte(T_IAC);
    send_byte(T_IAC);
    send_byte(T_IAC);
    send_byte(T_SE);
    send_byte(T_IAC);
    send_byte(T_WILL);
    send_byte(8'hFF);
    send_byte(T_IAC);
    send_byte(T_WONT);
    send_byte(OPT_NAWS);
    send_byte(T_IAC);
    send_byte(T_DO);
    send_byte(OPT_ECHO);
    send_byte(T_IAC);
    send_byte(T_DONT);
    send_byte(OPT_SGA);
    send_subneg(OPT_NAWS, {16'd1, SIZE_LIMIT_RST - 16'd1}, 4, T_SE);
    wait_results_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          limit = 16'hFFFF;
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          limit = 16'($urandom_range(2, 2000));
          sender_idle_pct = 82;
          receiver_stall_pct = 0;
        end
        2: begin
          limit = 16'd0;
          sender_idle_pct = 0;
          receiver_stall_pct = 82;
        end
        3: begin
          limit = 16'd1;
          sender_idle_pct = 28;
          receiver_stall_pct = 28;
        end
        default: begin
          limit = SIZE_LIMIT_RST;
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      write_size_limit(limit);
      phase_end = items_sent + 45;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 49) == 0) wait_results_drained();
        send_random_sequence();
      end
      wait_results_drained();
    end

    receiver_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
